// ----- design/ace_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ace_pkg
// Types, codes and constants shared by the alignment consensus engine.
// ----------------------------------------------------------------------------
package ace_pkg;

   // Default sizes of the column count store.
   localparam int MAX_COLUMNS_DEFAULT = 1024;
   localparam int MAX_CODES_DEFAULT   = 16;

   // Field and counter widths.
   localparam int OpW        = 2;
   localparam int ColumnW    = 10;
   localparam int SymbolW    = 4;
   localparam int CodeCountW = 5;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 5;
   localparam int ColCountW  = 17;
   localparam int GlobCountW = 32;

   // Operation codes.
   localparam logic [OpW-1:0] OP_ADD   = 2'd0;
   localparam logic [OpW-1:0] OP_QUERY = 2'd1;
   localparam logic [OpW-1:0] OP_CLEAR = 2'd2;

   // Register indexes.
   localparam logic [CsrIndexW-1:0] CSR_GAP_CODE     = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_MISSING_CODE = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_CODE_COUNT   = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_COUNT_GAPS   = 2'd3;

   // Register reset values.
   localparam logic [SymbolW-1:0]    GAP_CODE_RESET     = 4'd4;
   localparam logic [SymbolW-1:0]    MISSING_CODE_RESET = 4'd15;
   localparam logic [CodeCountW-1:0] CODE_COUNT_RESET   = 5'd4;

   typedef struct packed {
      logic [OpW-1:0]     operation;
      logic [ColumnW-1:0] column;
      logic [SymbolW-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [ColumnW-1:0] result_column;
      logic [SymbolW-1:0] consensus_code;
      logic               column_empty;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_WR,
      ST_Q_WALK,
      ST_Q_DONE
   } state_type;

endpackage : ace_pkg
`default_nettype wire

// ----- design/alignment_consensus_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alignment_consensus_engine
// Per-column symbol vote counter with a consensus query. Column counts live in
// one row-wide memory (one row of code counters per column); the global
// per-code tallies live in flip-flops.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_type (operation, column, symbol)
//   rsp      out        rsp_valid/rsp_ready    rsp_type (column, code, empty flag)
//   csr      in         csr_we                 csr_index, csr_wdata
//
// An add reads the row at acceptance, then writes the modified row back. A
// skipped add or an unknown operation returns straight to idle. A query does
// one row read, then one compare per code up to the clamped code count through
// a single comparator, then the result load. Reset and a clear item start a
// clearing pass, one row a cycle, during which no item is accepted. A query
// waits in its last state while an earlier result has not been taken; no item
// is accepted meanwhile.
//
module alignment_consensus_engine
   import ace_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
   parameter int MAX_CODES   = MAX_CODES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CsrIndexW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0]   csr_wdata
);

   localparam int ColAddrW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CodeW    = $clog2(MAX_CODES);
   localparam int CntW     = CodeW + 1;
   localparam int RowW     = MAX_CODES * ColCountW;
   localparam int KeyW     = ColCountW + GlobCountW;

   localparam logic [ColAddrW-1:0] LastRow = ColAddrW'(MAX_COLUMNS - 1);

   // Configuration registers.
   logic [SymbolW-1:0]    gap_code_ff;
   logic [SymbolW-1:0]    missing_code_ff;
   logic [CodeCountW-1:0] code_count_ff;
   logic                  count_gaps_ff;

   state_type state_ff, state_in;

   logic [ColAddrW-1:0]   clr_ff;
   logic [ColumnW-1:0]    col_ff;
   logic                  col_ok_ff;
   logic [CodeW-1:0]      sym_ff;
   logic [CodeW-1:0]      idx_ff;
   logic [CodeW-1:0]      pick_ff;
   logic [KeyW-1:0]       best_ff;
   logic                  empty_ff;
   logic [GlobCountW-1:0] glob_ff [MAX_CODES];

   logic                  rsp_valid_ff;
   rsp_type               rsp_payload_ff;

   // Column count memory, one row of code counters per column.
   logic [RowW-1:0]       col_mem [MAX_COLUMNS];
   logic [RowW-1:0]       rd_data_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [ColAddrW-1:0]   mem_addr;
   logic [RowW-1:0]       mem_wdata;

   logic                  accept;
   logic                  col_in_range;
   logic                  add_ok;
   logic [CntW-1:0]       n_codes;
   logic                  step_en;
   logic                  last_step;
   logic                  take;
   logic                  any_votes;
   logic                  rsp_free;
   logic [CodeW-1:0]      gidx;
   logic [GlobCountW-1:0] glob_rd;
   logic [ColCountW-1:0]  lane_rd;
   logic [ColCountW-1:0]  lane_old;
   logic [KeyW-1:0]       key;
   logic [RowW-1:0]       row_upd;

   // ------------------------------------------------------------------
   // Decode of the offered item and of the walk position.
   // ------------------------------------------------------------------
   assign accept       = req_valid && req_ready;
   assign col_in_range = 32'(req_payload.column) < MAX_COLUMNS;
   assign add_ok       = (req_payload.symbol != missing_code_ff)
                      && !((req_payload.symbol == gap_code_ff) && !count_gaps_ff)
                      && col_in_range
                      && (32'(req_payload.symbol) < MAX_CODES);
   assign n_codes      = (32'(code_count_ff) > MAX_CODES) ? CntW'(MAX_CODES)
                                                          : CntW'(code_count_ff);
   assign step_en      = (state_ff == ST_Q_WALK) && (CntW'(idx_ff) < n_codes);
   assign last_step    = (CntW'(idx_ff) + CntW'(1)) >= n_codes;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // One read port on the global tallies, shared by add and query.
   assign gidx    = (state_ff == ST_ADD_WR) ? sym_ff : idx_ff;
   assign glob_rd = glob_ff[gidx];

   // An out-of-range column reads as an all-zero row.
   assign lane_rd = col_ok_ff ? rd_data_ff[idx_ff*ColCountW +: ColCountW] : '0;
   assign key     = {lane_rd, glob_rd};
   // Votes first, global tally second; equal keys keep the lower code.
   assign take    = step_en && ((idx_ff == '0) || (key > best_ff));

   always_comb begin
      any_votes = 1'b0;
      for (int j = 0; j < MAX_CODES; j++) begin
         if ((CntW'(j) < n_codes) && (rd_data_ff[j*ColCountW +: ColCountW] != '0)) begin
            any_votes = 1'b1;
         end
      end
      any_votes = any_votes && col_ok_ff;
   end

   // Saturating increment of one lane of the row read back.
   assign lane_old = rd_data_ff[sym_ff*ColCountW +: ColCountW];
   always_comb begin
      row_upd = rd_data_ff;
      if (lane_old != {ColCountW{1'b1}}) begin
         row_upd[sym_ff*ColCountW +: ColCountW] = lane_old + ColCountW'(1);
      end
   end

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LastRow) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.operation)
                  OP_ADD:   if (add_ok) state_in = ST_ADD_WR;
                  OP_QUERY: state_in = ST_Q_WALK;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_WR: state_in = ST_IDLE;
         ST_Q_WALK: begin
            if (last_step) state_in = ST_Q_DONE;
         end
         ST_Q_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs of the state machine.
   // ------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = ColAddrW'(col_ff);
      mem_wdata = row_upd;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_addr  = ColAddrW'(req_payload.column);
            mem_re    = req_valid && col_in_range
                     && (((req_payload.operation == OP_ADD) && add_ok)
                         || (req_payload.operation == OP_QUERY));
         end
         ST_ADD_WR: begin
            mem_we   = 1'b1;
            mem_addr = ColAddrW'(col_ff);
         end
         ST_Q_WALK, ST_Q_DONE: begin
            mem_addr = ColAddrW'(col_ff);
         end
         default: begin
            mem_addr = ColAddrW'(col_ff);
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Column count memory.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) col_mem[mem_addr] <= mem_wdata;
      if (mem_re) rd_data_ff <= col_mem[mem_addr];
   end

   // ------------------------------------------------------------------
   // Control registers, configuration and global tallies.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         gap_code_ff     <= GAP_CODE_RESET;
         missing_code_ff <= MISSING_CODE_RESET;
         code_count_ff   <= CODE_COUNT_RESET;
         count_gaps_ff   <= 1'b0;
         for (int k = 0; k < MAX_CODES; k++) glob_ff[k] <= '0;
      end else begin
         state_ff <= state_in;

         if (state_ff == ST_CLEAR) clr_ff <= (clr_ff == LastRow) ? '0 : clr_ff + 1'b1;

         if ((state_ff == ST_Q_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            unique case (csr_index)
               CSR_GAP_CODE:     gap_code_ff     <= csr_wdata[SymbolW-1:0];
               CSR_MISSING_CODE: missing_code_ff <= csr_wdata[SymbolW-1:0];
               CSR_CODE_COUNT:   code_count_ff   <= csr_wdata[CodeCountW-1:0];
               CSR_COUNT_GAPS:   count_gaps_ff   <= csr_wdata[0];
               default:          ;
            endcase
         end

         if (accept && (req_payload.operation == OP_CLEAR)) begin
            for (int k = 0; k < MAX_CODES; k++) glob_ff[k] <= '0;
         end else if ((state_ff == ST_ADD_WR) && (glob_rd != {GlobCountW{1'b1}})) begin
            glob_ff[sym_ff] <= glob_rd + GlobCountW'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Item and walk payload registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff    <= req_payload.column;
         col_ok_ff <= col_in_range;
         sym_ff    <= CodeW'(req_payload.symbol);
         idx_ff    <= '0;
         pick_ff   <= '0;
      end else if (state_ff == ST_Q_WALK) begin
         if (take) begin
            pick_ff <= idx_ff;
            best_ff <= key;
         end
         if (!last_step) idx_ff <= idx_ff + 1'b1;
         if (last_step)  empty_ff <= !any_votes;
      end

      if ((state_ff == ST_Q_DONE) && rsp_free) begin
         rsp_payload_ff.result_column  <= col_ff;
         rsp_payload_ff.consensus_code <= SymbolW'(pick_ff);
         rsp_payload_ff.column_empty   <= empty_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // The memory has one port: a read and a write never share a cycle.
   a_one_port: assert property (@(posedge clock) !(mem_we && mem_re))
      else $error("column memory read and write in the same cycle");

   // Reset always starts the clearing pass before any item is taken.
   a_reset_clear: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("item accepted right after reset");

   // A result appears only after a query has finished its walk.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_Q_DONE))
      else $error("result raised outside a query");

   // The chosen code lies among the codes compared.
   a_pick_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_Q_DONE) && (n_codes != '0)) |-> (CntW'(pick_ff) < n_codes))
      else $error("consensus code beyond the compared codes");

endmodule : alignment_consensus_engine
`default_nettype wire

// ----- tb/tb_alignment_consensus_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alignment_consensus_engine
// Drives add, query, clear and unused items into the consensus engine through
// bursty traffic. The result side stalls on its own schedule. A tracker keeps
// its own column and global vote tallies and checks every consensus result in
// order. Register settings change between rounds while the engine is idle.
// ----------------------------------------------------------------------------
module tb_alignment_consensus_engine;
   import ace_pkg::*;

   localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = MAX_COLUMNS_DEFAULT + 64;
   localparam int DRAIN_CYCLES    = 64;
   localparam int HOLD_CYCLES     = 400;
   localparam int RANDOM_ROUNDS   = 8;
   localparam int ITEMS_PER_ROUND = 190;
   localparam int CYCLE_LIMIT     = 1_500_000;

   // Keeps its own vote tallies and the list of consensus results still owed.
   class consensus_tracker;
      bit [ColCountW-1:0]  column_tally [MAX_COLUMNS_DEFAULT][MAX_CODES_DEFAULT];
      bit [GlobCountW-1:0] code_tally [MAX_CODES_DEFAULT];
      bit [SymbolW-1:0]    gap_code;
      bit [SymbolW-1:0]    missing_code;
      bit [CodeCountW-1:0] code_count;
      bit                  count_gaps;
      rsp_type             consensus_due [$];
      int unsigned         mismatches;

      function new();
         gap_code     = GAP_CODE_RESET;
         missing_code = MISSING_CODE_RESET;
         code_count   = CODE_COUNT_RESET;
         count_gaps   = 1'b0;
         mismatches   = 0;
         clear_tallies();
      endfunction

      function void clear_tallies();
         for (int c = 0; c < MAX_COLUMNS_DEFAULT; c++) begin
            for (int s = 0; s < MAX_CODES_DEFAULT; s++) begin
               column_tally[c][s] = '0;
            end
         end
         for (int s = 0; s < MAX_CODES_DEFAULT; s++) begin
            code_tally[s] = '0;
         end
      endfunction

      function void write_register(logic [CsrIndexW-1:0] index, logic [CsrDataW-1:0] data);
         case (index)
            CSR_GAP_CODE: begin
               gap_code = data[SymbolW-1:0];
            end
            CSR_MISSING_CODE: begin
               missing_code = data[SymbolW-1:0];
            end
            CSR_CODE_COUNT: begin
               code_count = data[CodeCountW-1:0];
            end
            CSR_COUNT_GAPS: begin
               count_gaps = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_request(req_type item);
         int               codes;
         bit               voted;
         bit [SymbolW-1:0] pick;
         bit [GlobCountW-1:0] best;
         rsp_type          want;
         case (item.operation)
            OP_ADD: begin
               // A missing symbol is never counted, even when it is also the gap code.
               if (item.symbol != missing_code &&
                   (item.symbol != gap_code || count_gaps)) begin
                  if (column_tally[item.column][item.symbol] != '1)
                     column_tally[item.column][item.symbol]++;
                  if (code_tally[item.symbol] != '1)
                     code_tally[item.symbol]++;
               end
            end
            OP_QUERY: begin
               codes = (code_count > MAX_CODES_DEFAULT) ? MAX_CODES_DEFAULT : int'(code_count);
               voted = 1'b0;
               pick  = '0;
               for (int i = 0; i < codes; i++) begin
                  if (column_tally[item.column][i] != 0) voted = 1'b1;
               end
               if (voted) begin
                  best = column_tally[item.column][0];
                  for (int i = 1; i < codes; i++) begin
                     if (column_tally[item.column][i] > best) begin
                        best = column_tally[item.column][i];
                        pick = SymbolW'(i);
                     end else if (column_tally[item.column][i] == best &&
                                  code_tally[i] > code_tally[pick]) begin
                        pick = SymbolW'(i);
                     end
                  end
               end else if (codes > 0) begin
                  best = code_tally[0];
                  for (int i = 1; i < codes; i++) begin
                     if (code_tally[i] > best) begin
                        best = code_tally[i];
                        pick = SymbolW'(i);
                     end
                  end
               end
               want.result_column  = item.column;
               want.consensus_code = pick;
               want.column_empty   = !voted;
               consensus_due.push_back(want);
            end
            OP_CLEAR: begin
               clear_tallies();
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (consensus_due.size() == 0) begin
            $error("consensus result for column %0d with none outstanding",
                   got.result_column);
            mismatches++;
            return;
         end
         want = consensus_due.pop_front();
         if (got.result_column !== want.result_column) begin
            $error("result_column: expected %0d, got %0d",
                   want.result_column, got.result_column);
            mismatches++;
         end
         if (got.consensus_code !== want.consensus_code) begin
            $error("consensus_code: expected %0d, got %0d",
                   want.consensus_code, got.consensus_code);
            mismatches++;
         end
         if (got.column_empty !== want.column_empty) begin
            $error("column_empty: expected %0d, got %0d",
                   want.column_empty, got.column_empty);
            mismatches++;
         end
      endfunction

      function int pending();
         return consensus_due.size();
      endfunction
   endclass

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_we      = 1'b0;
   logic [CsrIndexW-1:0] csr_index   = '0;
   logic [CsrDataW-1:0]  csr_wdata   = '0;

   consensus_tracker     tracker;
   logic [ColumnW-1:0]   hot_columns [8];
   logic                 long_hold   = 1'b0;
   int unsigned          cycle_count = 0;

   alignment_consensus_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic req_type make_item(logic [OpW-1:0] op, logic [ColumnW-1:0] col,
                                         logic [SymbolW-1:0] sym);
      req_type item;
      item.operation = op;
      item.column    = col;
      item.symbol    = sym;
      return item;
   endfunction

   // Mostly adds and queries on a few busy columns with low codes, so that
   // counts build up and ties occur; the rest is spread over the full range.
   function automatic req_type random_item();
      req_type     item;
      int unsigned roll;
      roll = $urandom_range(0, 999);
      if (roll < 8)        item.operation = OP_CLEAR;
      else if (roll < 40)  item.operation = OP_UNUSED;
      else if (roll < 300) item.operation = OP_QUERY;
      else                 item.operation = OP_ADD;
      roll = $urandom_range(0, 9);
      if (roll < 8) item.column = hot_columns[$urandom_range(0, 7)];
      else          item.column = ColumnW'($urandom_range(0, 1023));
      roll = $urandom_range(0, 9);
      if (roll < 6)       item.symbol = SymbolW'($urandom_range(0, 5));
      else if (roll == 6) item.symbol = tracker.gap_code;
      else if (roll == 7) item.symbol = tracker.missing_code;
      else                item.symbol = SymbolW'($urandom_range(0, 15));
      return item;
   endfunction

   task automatic send_item(input req_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CsrIndexW-1:0] index,
                                 input logic [CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      tracker.write_register(index, data);
      @(posedge clock);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned done;
      int unsigned burst;
      req_type     item;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && done < count; k++) begin
            item = random_item();
            done++;
            send_item(item);
         end
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_payload);
         if (req_valid && req_ready) tracker.note_request(req_payload);
      end
   end

   initial begin : result_side
      int unsigned run;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         if ($urandom_range(0, 3) != 0 && !long_hold) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_alignment_consensus_engine: errors");
      $finish;
   end

   initial begin : stimulus
      logic [SymbolW-1:0]    gap_sel;
      logic [SymbolW-1:0]    missing_sel;
      logic [CodeCountW-1:0] codes_sel;
      logic                  gaps_sel;
      logic [CsrDataW-1:0]   spare;
      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: gap 4, missing 15, four codes compared, gaps skipped.
      send_item(make_item(OP_QUERY, 10'd0, 4'd0));
      send_item(make_item(OP_ADD, 10'd0, 4'd0));
      send_item(make_item(OP_ADD, 10'd1023, 4'd3));
      send_item(make_item(OP_ADD, 10'd1023, 4'd3));
      send_item(make_item(OP_ADD, 10'd1023, 4'd1));
      send_item(make_item(OP_QUERY, 10'd1023, 4'd0));
      // Equal column and global counts: the lower code wins.
      send_item(make_item(OP_ADD, 10'd1023, 4'd1));
      send_item(make_item(OP_QUERY, 10'd1023, 4'd15));
      // One more global vote for code 3 breaks the column tie.
      send_item(make_item(OP_ADD, 10'd5, 4'd3));
      send_item(make_item(OP_QUERY, 10'd1023, 4'd0));
      send_item(make_item(OP_QUERY, 10'd7, 4'd0));
      send_item(make_item(OP_ADD, 10'd6, 4'd15));
      send_item(make_item(OP_ADD, 10'd6, 4'd4));
      // Code 9 is counted but lies outside the compared codes.
      send_item(make_item(OP_ADD, 10'd6, 4'd9));
      send_item(make_item(OP_QUERY, 10'd6, 4'd0));
      send_item(make_item(OP_UNUSED, 10'd1023, 4'd15));
      send_item(make_item(OP_ADD, 10'd1023, 4'd2));
      send_item(make_item(OP_CLEAR, 10'd0, 4'd0));
      send_item(make_item(OP_QUERY, 10'd1023, 4'd0));
      req_valid <= 1'b0;

      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         // Registers change only with nothing outstanding and any clearing pass over.
         while (tracker.pending() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (round)
            0: begin
               gap_sel = 4'd0;  missing_sel = 4'd0;  codes_sel = 5'd16; gaps_sel = 1'b1;
            end
            1: begin
               gap_sel = 4'd15; missing_sel = 4'd15; codes_sel = 5'd0;  gaps_sel = 1'b1;
            end
            2: begin
               gap_sel = 4'd7;  missing_sel = 4'd3;  codes_sel = 5'd31; gaps_sel = 1'b0;
            end
            3: begin
               gap_sel = 4'd15; missing_sel = 4'd0;  codes_sel = 5'd1;  gaps_sel = 1'b1;
            end
            4: begin
               gap_sel = 4'd2;  missing_sel = 4'd14; codes_sel = 5'd5;  gaps_sel = 1'b1;
            end
            default: begin
               gap_sel     = SymbolW'($urandom_range(0, 15));
               missing_sel = SymbolW'($urandom_range(0, 15));
               codes_sel   = CodeCountW'($urandom_range(0, 31));
               gaps_sel    = 1'($urandom_range(0, 1));
            end
         endcase
         // The unused upper data bits alternate between rounds.
         spare = (round % 2 == 1) ? '1 : '0;
         write_register(CSR_GAP_CODE, {spare[4], gap_sel});
         write_register(CSR_MISSING_CODE, {spare[4], missing_sel});
         write_register(CSR_CODE_COUNT, codes_sel);
         write_register(CSR_COUNT_GAPS, {spare[3:0], gaps_sel});
         csr_we <= 1'b0;

         hot_columns[0] = '0;
         hot_columns[1] = '1;
         for (int k = 2; k < 8; k++) hot_columns[k] = ColumnW'($urandom_range(0, 1023));
         if (round == 2) long_hold = 1'b1;
         run_random(ITEMS_PER_ROUND);
      end

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("tb_alignment_consensus_engine: clean");
      else
         $display("tb_alignment_consensus_engine: errors");
      $finish;
   end

endmodule
